/* rtl/sharp_pkg.sv */
// Shared types and constants for the 3x3 sharpen filter.
// Used by every module of the block; depends on nothing else.
package sharp_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = 12;
    localparam int DIM_W       = 12;
    localparam int CHAN_W      = 8;
    localparam int NUM_COLOR   = 3;
    localparam int SUM_W       = 12;
    localparam int LANES       = 4;
    localparam int LANE_IDX_W  = $clog2(LANES);
    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;
    localparam int NCNT_W      = $clog2(LANES) + 1;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    // Kernel: the center weighs CENTER_WEIGHT, each edge neighbor (up, left, right, down) weighs -1, corners 0.
    localparam int CENTER_WEIGHT = 5;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);
    localparam logic [DIM_W-1:0] MIN_DIM      = DIM_W'(2);
    localparam logic [DIM_W-1:0] MAX_W_DIM    = DIM_W'(MAX_WIDTH);
    localparam logic [COL_W-1:0] MAX_COL      = COL_W'(MAX_WIDTH - 1);

    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [CHAN_W-1:0] alpha;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } pixel_t;

    typedef struct packed {
        pixel_t up;
        pixel_t left;
        pixel_t center;
        pixel_t right;
        pixel_t down;
    } nbhd_t;

    typedef struct packed {
        logic [CHAN_W-1:0]    red;
        logic [CHAN_W-1:0]    green;
        logic [CHAN_W-1:0]    blue;
        logic [CHAN_W-1:0]    alpha;
        logic [ROW_W-1:0]     row;
        logic [COL_W-1:0]     column;
        logic [NUM_COLOR-1:0] clipped;
        logic                 last;
    } result_t;

    typedef struct packed {
        logic             push;
        logic [LANES-1:0] lane_en;
    } merge_ctl_t;

endpackage

/* rtl/sharp_line_buf.sv */
// Two line memories holding the previous and the older row of pixels.
// Depends on sharp_pkg for the pixel type and the row length.
module sharp_line_buf (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rd_en,
    input  logic [sharp_pkg::COL_W-1:0] addr,
    input  sharp_pkg::pixel_t          px_in,
    output sharp_pkg::pixel_t          prev_out,
    output sharp_pkg::pixel_t          older_out
);
    import sharp_pkg::*;

    pixel_t            prev_mem  [MAX_WIDTH];
    pixel_t            older_mem [MAX_WIDTH];
    pixel_t            prev_rd_reg;
    pixel_t            older_rd_reg;
    logic [COL_W-1:0]  addr_reg;
    logic              shift_reg;

    // The older row takes the word just read from the previous row in the next
    // cycle; consecutive pixels never share a column, so no hazard.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            prev_rd_reg    <= prev_mem[addr];
            older_rd_reg   <= older_mem[addr];
            prev_mem[addr] <= px_in;
            addr_reg       <= addr;
        end
        if (shift_reg)
        begin
            older_mem[addr_reg] <= prev_rd_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= 1'b0;
        end
        else
        begin
            shift_reg <= rd_en;
        end
    end

    assign prev_out  = prev_rd_reg;
    assign older_out = older_rd_reg;

endmodule

/* rtl/sharp_lane.sv */
// One kernel lane: the sharpen sum of red, green and blue for one output pixel.
// Depends on sharp_pkg for the neighborhood and result types.
module sharp_lane (
    input  sharp_pkg::nbhd_t            nb,
    input  logic [sharp_pkg::ROW_W-1:0] row,
    input  logic [sharp_pkg::COL_W-1:0] column,
    output sharp_pkg::result_t          res
);
    import sharp_pkg::*;

    logic [SUM_W-1:0] sum [NUM_COLOR];

    // The sum lies in -1020..1275, so twelve bits in two's complement hold it
    // and any set bit above the low byte means it left 0..255.
    always_comb
    begin
        for (int i = 0; i < NUM_COLOR; i++)
        begin
            sum[i] = SUM_W'(CENTER_WEIGHT) * SUM_W'(nb.center[CHAN_W*i +: CHAN_W])
                   - SUM_W'(nb.up[CHAN_W*i +: CHAN_W])
                   - SUM_W'(nb.left[CHAN_W*i +: CHAN_W])
                   - SUM_W'(nb.right[CHAN_W*i +: CHAN_W])
                   - SUM_W'(nb.down[CHAN_W*i +: CHAN_W]);
        end
    end

    always_comb
    begin
        res.red     = sum[0][CHAN_W-1:0];
        res.green   = sum[1][CHAN_W-1:0];
        res.blue    = sum[2][CHAN_W-1:0];
        res.alpha   = nb.center.alpha;
        res.row     = row;
        res.column  = column;
        res.clipped = {|sum[2][SUM_W-1:CHAN_W], |sum[1][SUM_W-1:CHAN_W],
                       |sum[0][SUM_W-1:CHAN_W]};
        res.last    = 1'b0;
    end

endmodule

/* rtl/sharp_merge.sv */
// Result queue that packs the enabled lane results in order and hands them
// out one transfer at a time. Depends on sharp_pkg.
module sharp_merge (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  sharp_pkg::merge_ctl_t                  ctl,
    input  sharp_pkg::result_t [sharp_pkg::LANES-1:0] lane_res,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output sharp_pkg::result_t                     head,
    output logic [sharp_pkg::QCNT_W-1:0]           count
);
    import sharp_pkg::*;

    result_t               queue_mem [QUEUE_DEPTH];
    result_t               res_mod   [LANES];
    logic [QPTR_W-1:0]     offset    [LANES];
    logic [QPTR_W-1:0]     head_reg;
    logic [QPTR_W-1:0]     tail_reg;
    logic [QCNT_W-1:0]     count_reg;
    logic [LANE_IDX_W-1:0] last_idx;
    logic [NCNT_W-1:0]     npush;
    logic                  pop;

    // Lanes 0 and 1 belong to the left output column, 2 and 3 to the right;
    // the second lane of each pair is only enabled along with the first.
    always_comb
    begin
        offset[0] = '0;
        offset[1] = QPTR_W'(1);
        offset[2] = QPTR_W'(ctl.lane_en[0]) + QPTR_W'(ctl.lane_en[1]);
        offset[3] = offset[2] + QPTR_W'(1);
        npush = '0;
        for (int i = 0; i < LANES; i++)
        begin
            npush = npush + NCNT_W'(ctl.lane_en[i]);
        end
        if (ctl.lane_en[2])
        begin
            last_idx = ctl.lane_en[3] ? LANE_IDX_W'(3) : LANE_IDX_W'(2);
        end
        else
        begin
            last_idx = ctl.lane_en[1] ? LANE_IDX_W'(1) : LANE_IDX_W'(0);
        end
        for (int i = 0; i < LANES; i++)
        begin
            res_mod[i]      = lane_res[i];
            res_mod[i].last = (LANE_IDX_W'(i) == last_idx);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                if (ctl.lane_en[i])
                begin
                    queue_mem[QPTR_W'(tail_reg + offset[i])] <= res_mod[i];
                end
            end
        end
    end

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid & out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (ctl.push)
            begin
                tail_reg <= QPTR_W'(tail_reg + QPTR_W'(npush));
            end
            if (pop)
            begin
                head_reg <= head_reg + QPTR_W'(1);
            end
            count_reg <= count_reg + QCNT_W'(ctl.push ? npush : '0) - QCNT_W'(pop);
        end
    end

    assign head  = queue_mem[head_reg];
    assign count = count_reg;

endmodule

/* rtl/sharpen_3x3_conv_replicate_edge.sv */
// 3x3 sharpen filter over a raster-order RGBA pixel stream with edge
// replication at the frame borders.
//
// Pixels enter on the in channel (valid/ready) one per transfer, row after
// row. Results leave on the out channel, one output pixel per transfer, in
// the order column, then row within a column pair. An output pixel is known
// once the pixel one row below and one column right has arrived, so it
// appears one row plus one pixel after its own input; it is computed from
// the input stage registers and becomes valid once written to the queue.
// A pixel yields zero to four results: none in the first row or column, one
// inside the frame, two at a row end, twice that on the last row. The block
// takes one pixel per clock while at most one result per pixel comes out;
// on the last row the output port (one result per clock) sets the pace.
// An eight-entry result queue decouples the sides: in_ready drops only when
// the queue could not hold the results of the pixels in flight, so a stall
// on out_ready backs up to the input as the queue fills.
// Frame size is set through the APB port (width at 0x0, height at 0x4) and
// may only change while the block is idle. Reset empties the queue, zeroes
// the window and the position counters and loads a 640x480 frame; the line
// memories are not cleared.
// Depends on sharp_pkg, sharp_line_buf, sharp_lane and sharp_merge.
module sharpen_3x3_conv_replicate_edge (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sharp_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [sharp_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [sharp_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [sharp_pkg::CHAN_W-1:0]        red,
    input  logic [sharp_pkg::CHAN_W-1:0]        green,
    input  logic [sharp_pkg::CHAN_W-1:0]        blue,
    input  logic [sharp_pkg::CHAN_W-1:0]        alpha,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [sharp_pkg::CHAN_W-1:0]        out_red,
    output logic [sharp_pkg::CHAN_W-1:0]        out_green,
    output logic [sharp_pkg::CHAN_W-1:0]        out_blue,
    output logic [sharp_pkg::CHAN_W-1:0]        out_alpha,
    output logic [sharp_pkg::ROW_W-1:0]         out_row,
    output logic [sharp_pkg::COL_W-1:0]         out_column,
    output logic [sharp_pkg::NUM_COLOR-1:0]     clipped,
    output logic                                run_last
);
    import sharp_pkg::*;

    logic [DIM_W-1:0]      frame_width_reg;
    logic [DIM_W-1:0]      frame_height_reg;
    logic [COL_W-1:0]      last_col;
    logic [ROW_W-1:0]      last_row_idx;
    logic [COL_W-1:0]      col_reg;
    logic [ROW_W-1:0]      row_reg;
    logic                  row_end;
    logic                  last_row;
    logic [LANES-1:0]      lane_en;
    logic [NCNT_W-1:0]     n_new;
    logic [QCNT_W:0]       need;
    logic [QCNT_W-1:0]     q_count;
    logic                  accept;
    pixel_t                in_px;

    logic                  s1_valid_reg;
    logic [LANES-1:0]      s1_en_reg;
    logic [NCNT_W-1:0]     s1_n_reg;
    pixel_t                s1_px_reg;
    logic [ROW_W-1:0]      s1_row_reg;
    logic [COL_W-1:0]      s1_col_reg;
    logic                  s1_row_is1_reg;
    logic                  s1_col_is1_reg;

    pixel_t                prev_px;
    pixel_t                older_px;
    pixel_t                win_reg  [3][3];
    pixel_t                win_next [3][3];
    logic [1:0]            up_row;
    logic [1:0]            left_col;

    nbhd_t                 lane_in  [LANES];
    logic [ROW_W-1:0]      lane_row [LANES];
    logic [COL_W-1:0]      lane_col [LANES];
    result_t [LANES-1:0]   lane_res;
    merge_ctl_t            merge_ctl;
    result_t               head;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= WIDTH_RESET;
            frame_height_reg <= HEIGHT_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (reg_index_t'(paddr[2]))
                REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[DIM_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[DIM_W-1:0];
                default:          frame_width_reg  <= frame_width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index_t'(paddr[2]))
            REG_FRAME_WIDTH:  prdata = APB_DATA_W'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = APB_DATA_W'(frame_height_reg);
            default:          prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // Effective frame size: width held to 2..MAX_WIDTH, height raised to 2.
    always_comb
    begin
        if (frame_width_reg < MIN_DIM)
        begin
            last_col = COL_W'(1);
        end
        else if (frame_width_reg > MAX_W_DIM)
        begin
            last_col = MAX_COL;
        end
        else
        begin
            last_col = COL_W'(frame_width_reg - 1'b1);
        end
        last_row_idx = (frame_height_reg < MIN_DIM) ? ROW_W'(1)
                                                    : ROW_W'(frame_height_reg - 1'b1);
    end

    assign row_end  = (col_reg >= last_col);
    assign last_row = (row_reg >= last_row_idx);

    // Lanes 0/1: output column c-1 (its row, then the last row).
    // Lanes 2/3: output column c at a row end.
    assign lane_en[0] = (row_reg != '0) && (col_reg != '0);
    assign lane_en[1] = lane_en[0] && last_row;
    assign lane_en[2] = (row_reg != '0) && row_end;
    assign lane_en[3] = lane_en[2] && last_row;

    assign n_new = NCNT_W'(lane_en[0]) + NCNT_W'(lane_en[1])
                 + NCNT_W'(lane_en[2]) + NCNT_W'(lane_en[3]);

    // Room must exist for everything queued, in flight and about to enter.
    assign need     = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(s1_n_reg) + (QCNT_W+1)'(n_new);
    assign in_ready = (need <= (QCNT_W+1)'(QUEUE_DEPTH));
    assign accept   = in_valid & in_ready;

    assign in_px = '{alpha: alpha, blue: blue, green: green, red: red};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s1_en_reg    <= '0;
            s1_n_reg     <= '0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s1_en_reg    <= accept ? lane_en : '0;
            s1_n_reg     <= accept ? n_new : '0;
            if (accept)
            begin
                if (row_end)
                begin
                    col_reg <= '0;
                    row_reg <= last_row ? '0 : row_reg + ROW_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_px_reg      <= in_px;
            s1_row_reg     <= row_reg;
            s1_col_reg     <= col_reg;
            s1_row_is1_reg <= (row_reg == ROW_W'(1));
            s1_col_is1_reg <= (col_reg == COL_W'(1));
        end
    end

    sharp_line_buf u_line_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (accept),
        .addr      (col_reg),
        .px_in     (in_px),
        .prev_out  (prev_px),
        .older_out (older_px)
    );

    // Window rows: two rows back, one row back, current row.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            win_next[k][0] = win_reg[k][1];
            win_next[k][1] = win_reg[k][2];
        end
        win_next[0][2] = older_px;
        win_next[1][2] = prev_px;
        win_next[2][2] = s1_px_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    win_reg[k][j] <= '0;
                end
            end
        end
        else if (s1_valid_reg)
        begin
            win_reg <= win_next;
        end
    end

    // On the second row the up neighbor is the center row itself, and in the
    // second column the left neighbor is the center column itself.
    assign up_row   = s1_row_is1_reg ? 2'd1 : 2'd0;
    assign left_col = s1_col_is1_reg ? 2'd1 : 2'd0;

    always_comb
    begin
        lane_in[0] = '{up: win_next[up_row][1], left: win_next[1][left_col],
                       center: win_next[1][1], right: win_next[1][2],
                       down: win_next[2][1]};
        lane_in[1] = '{up: win_next[1][1], left: win_next[2][left_col],
                       center: win_next[2][1], right: win_next[2][2],
                       down: win_next[2][1]};
        lane_in[2] = '{up: win_next[up_row][2], left: win_next[1][1],
                       center: win_next[1][2], right: win_next[1][2],
                       down: win_next[2][2]};
        lane_in[3] = '{up: win_next[1][2], left: win_next[2][1],
                       center: win_next[2][2], right: win_next[2][2],
                       down: win_next[2][2]};
        lane_row[0] = s1_row_reg - ROW_W'(1);
        lane_row[1] = s1_row_reg;
        lane_row[2] = s1_row_reg - ROW_W'(1);
        lane_row[3] = s1_row_reg;
        lane_col[0] = s1_col_reg - COL_W'(1);
        lane_col[1] = s1_col_reg - COL_W'(1);
        lane_col[2] = s1_col_reg;
        lane_col[3] = s1_col_reg;
    end

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        sharp_lane u_lane (
            .nb     (lane_in[i]),
            .row    (lane_row[i]),
            .column (lane_col[i]),
            .res    (lane_res[i])
        );
    end

    assign merge_ctl = '{push: s1_valid_reg, lane_en: s1_en_reg};

    sharp_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (merge_ctl),
        .lane_res  (lane_res),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head),
        .count     (q_count)
    );

    assign out_red    = head.red;
    assign out_green  = head.green;
    assign out_blue   = head.blue;
    assign out_alpha  = head.alpha;
    assign out_row    = head.row;
    assign out_column = head.column;
    assign clipped    = head.clipped;
    assign run_last   = head.last;

endmodule

/* rtl/sharp_checker.sv */
// Port-level checks for the sharpen filter, bound to its top level.
// Depends on sharp_pkg for field widths.
module sharp_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [sharp_pkg::CHAN_W-1:0]    out_red,
    input logic [sharp_pkg::CHAN_W-1:0]    out_green,
    input logic [sharp_pkg::CHAN_W-1:0]    out_blue,
    input logic [sharp_pkg::CHAN_W-1:0]    out_alpha,
    input logic [sharp_pkg::ROW_W-1:0]     out_row,
    input logic [sharp_pkg::COL_W-1:0]     out_column,
    input logic [sharp_pkg::NUM_COLOR-1:0] clipped,
    input logic                            run_last
);
    import sharp_pkg::*;

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable({out_red, out_green, out_blue, out_alpha,
                        out_row, out_column, clipped, run_last}))
        else $error("result changed while stalled");

    // The queue only fills from a pixel transfer that passed the input stage.
    a_fill_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result appeared without a pixel transfer");

    // All results of one pixel are queued together.
    a_run_whole: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !run_last |=> out_valid)
        else $error("run of results broken");

    // Within a run the next result is the pixel below, the next column in the same row, or the next column one row up.
    a_run_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !run_last |=>
            (out_column == $past(out_column) && out_row == $past(out_row) + ROW_W'(1))
         || (out_column == $past(out_column) + COL_W'(1) && out_row == $past(out_row))
         || (out_column == $past(out_column) + COL_W'(1)
             && out_row == $past(out_row) - ROW_W'(1)))
        else $error("results of one pixel out of order");

endmodule

bind sharpen_3x3_conv_replicate_edge sharp_checker u_sharp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .out_alpha  (out_alpha),
    .out_row    (out_row),
    .out_column (out_column),
    .clipped    (clipped),
    .run_last   (run_last)
);

/* test/sharpen_3x3_conv_replicate_edge_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for the 3x3 sharpen filter: mirrors the frame size registers, the
// line stores and the 3x3 window, predicts each output pixel and checks the out
// channel and APB reads. Depends on sharp_pkg only.
module sharpen_3x3_conv_replicate_edge_checker
    import sharp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic [APB_DATA_W-1:0] prdata,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [CHAN_W-1:0]     red,
    input  logic [CHAN_W-1:0]     green,
    input  logic [CHAN_W-1:0]     blue,
    input  logic [CHAN_W-1:0]     alpha,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [CHAN_W-1:0]     out_red,
    input  logic [CHAN_W-1:0]     out_green,
    input  logic [CHAN_W-1:0]     out_blue,
    input  logic [CHAN_W-1:0]     out_alpha,
    input  logic [ROW_W-1:0]      out_row,
    input  logic [COL_W-1:0]      out_column,
    input  logic [NUM_COLOR-1:0]  clipped,
    input  logic                  run_last,
    output int                    mismatches,
    output int                    outstanding,
    output int                    compared
);

    localparam int CHAN_MAX   = 2 ** CHAN_W - 1;
    localparam int MAX_REPORT = 10;

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    pixel_t           prev_row  [MAX_WIDTH];
    pixel_t           older_row [MAX_WIDTH];
    pixel_t           kernel_win [3][3];
    int unsigned      col_pos;
    int unsigned      row_pos;
    result_t          sharpened_q [$];
    result_t          batch [LANES];
    int               batch_len;
    int               errs;
    int               checks;
    result_t          got;
    result_t          want;
    reg_index_t       reg_idx;
    logic [DIM_W-1:0] reg_value;

    function automatic int sharpen_sum(logic [CHAN_W-1:0] up, logic [CHAN_W-1:0] lf,
                                       logic [CHAN_W-1:0] ce, logic [CHAN_W-1:0] rt,
                                       logic [CHAN_W-1:0] dn);
        return CENTER_WEIGHT * int'(ce) - int'(up) - int'(lf) - int'(rt) - int'(dn);
    endfunction

    function automatic result_t sharpen_one(pixel_t up, pixel_t lf, pixel_t ce, pixel_t rt,
                                            pixel_t dn, int unsigned row, int unsigned col);
        result_t res;
        int      sums [NUM_COLOR];
        sums[0] = sharpen_sum(up.red, lf.red, ce.red, rt.red, dn.red);
        sums[1] = sharpen_sum(up.green, lf.green, ce.green, rt.green, dn.green);
        sums[2] = sharpen_sum(up.blue, lf.blue, ce.blue, rt.blue, dn.blue);
        res.red    = CHAN_W'(sums[0]);
        res.green  = CHAN_W'(sums[1]);
        res.blue   = CHAN_W'(sums[2]);
        res.alpha  = ce.alpha;
        res.row    = ROW_W'(row);
        res.column = COL_W'(col);
        for (int i = 0; i < NUM_COLOR; i++)
            res.clipped[i] = (sums[i] < 0) || (sums[i] > CHAN_MAX);
        res.last = 1'b0;
        return res;
    endfunction

    // One output column of the window; the bottom row of the frame adds a
    // second pixel whose down neighbor is the center itself.
    task sharpen_column(int lc, int cc, int rc, int unsigned r, bit bottom, int unsigned col);
        int upr;
        // On row 1 the output row is the top row, so up replicates the center.
        upr = (r == 1) ? 1 : 0;
        batch[batch_len] = sharpen_one(kernel_win[upr][cc], kernel_win[1][lc],
                                       kernel_win[1][cc], kernel_win[1][rc],
                                       kernel_win[2][cc], r - 1, col);
        batch_len++;
        if (bottom) begin
            batch[batch_len] = sharpen_one(kernel_win[1][cc], kernel_win[2][lc],
                                           kernel_win[2][cc], kernel_win[2][rc],
                                           kernel_win[2][cc], r, col);
            batch_len++;
        end
    endtask

    task convolve_pixel(pixel_t px);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        pixel_t      older;
        pixel_t      prev;
        bit          row_end;
        bit          bottom;
        w = width_reg;
        if (w < 2) w = 2;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        h = height_reg;
        if (h < 2) h = 2;
        c = (col_pos > MAX_WIDTH - 1) ? MAX_WIDTH - 1 : col_pos;
        r = row_pos;

        older = older_row[c];
        prev  = prev_row[c];
        older_row[c] = prev;
        prev_row[c]  = px;
        for (int k = 0; k < 3; k++) begin
            kernel_win[k][0] = kernel_win[k][1];
            kernel_win[k][1] = kernel_win[k][2];
        end
        kernel_win[0][2] = older;
        kernel_win[1][2] = prev;
        kernel_win[2][2] = px;

        row_end   = (c >= w - 1);
        bottom    = (r >= h - 1);
        batch_len = 0;
        if (r >= 1) begin
            if (c >= 1)
                sharpen_column((c == 1) ? 1 : 0, 1, 2, r, bottom, c - 1);
            if (row_end)
                sharpen_column(1, 2, 2, r, bottom, c);
        end
        if (row_end) begin
            col_pos = 0;
            row_pos = bottom ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end

        if (batch_len > 0)
            batch[batch_len - 1].last = 1'b1;
        for (int i = 0; i < batch_len; i++)
            sharpened_q.push_back(batch[i]);
    endtask

    function automatic string show(result_t x);
        return $sformatf("rgba=%02h/%02h/%02h/%02h row=%0d col=%0d clip=%03b last=%0b",
                         x.red, x.green, x.blue, x.alpha, x.row, x.column, x.clipped, x.last);
    endfunction

    function automatic bit same_result(result_t a, result_t b);
        return a.red === b.red && a.green === b.green && a.blue === b.blue
            && a.alpha === b.alpha && a.row === b.row && a.column === b.column
            && a.clipped === b.clipped && a.last === b.last;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            for (int i = 0; i < MAX_WIDTH; i++) begin
                prev_row[i]  = '0;
                older_row[i] = '0;
            end
            for (int k = 0; k < 3; k++)
                for (int j = 0; j < 3; j++)
                    kernel_win[k][j] = '0;
            col_pos = 0;
            row_pos = 0;
            sharpened_q.delete();
            errs   = 0;
            checks = 0;
            mismatches  <= 0;
            outstanding <= 0;
            compared    <= 0;
        end else begin
            if (out_valid && out_ready) begin
                got = '{red: out_red, green: out_green, blue: out_blue, alpha: out_alpha,
                        row: out_row, column: out_column, clipped: clipped, last: run_last};
                checks++;
                if (sharpened_q.size() == 0) begin
                    if (errs < MAX_REPORT)
                        $display("%0t: unexpected result %s", $time, show(got));
                    errs++;
                end else begin
                    want = sharpened_q.pop_front();
                    if (!same_result(want, got)) begin
                        if (errs < MAX_REPORT)
                            $display("%0t: mismatch\n    expected %s\n    actual   %s",
                                     $time, show(want), show(got));
                        errs++;
                    end
                end
            end

            if (psel && penable && pready) begin
                reg_idx = reg_index_t'(paddr[APB_ADDR_W-1]);
                if (pwrite) begin
                    if (reg_idx == REG_FRAME_WIDTH)
                        width_reg = pwdata[DIM_W-1:0];
                    else
                        height_reg = pwdata[DIM_W-1:0];
                end else begin
                    reg_value = (reg_idx == REG_FRAME_WIDTH) ? width_reg : height_reg;
                    if (prdata !== APB_DATA_W'(reg_value)) begin
                        if (errs < MAX_REPORT)
                            $display("%0t: %s read back %0h, expected %0h", $time,
                                     reg_idx.name(), prdata, reg_value);
                        errs++;
                    end
                end
            end

            if (in_valid && in_ready)
                convolve_pixel({alpha, blue, green, red});

            mismatches  <= errs;
            outstanding <= sharpened_q.size();
            compared    <= checks;
        end
    end

endmodule

/* test/sharpen_3x3_conv_replicate_edge_tb.sv */
`timescale 1ns / 100ps
// Top of the sharpen filter testbench: programs frame sizes, streams pixels
// and gives the verdict. Depends on sharp_pkg, the filter RTL and the checker.
module sharpen_3x3_conv_replicate_edge_tb;
    import sharp_pkg::*;

    localparam int RANDOM_PIXELS = 250;
    localparam int IDLE_PERCENT  = 11;
    localparam int DRAIN_CYCLES  = 16;
    localparam int STALL_LIMIT   = 2000;
    localparam int RESET_CYCLES  = 12;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid;
    logic                  in_ready;
    logic [CHAN_W-1:0]     red;
    logic [CHAN_W-1:0]     green;
    logic [CHAN_W-1:0]     blue;
    logic [CHAN_W-1:0]     alpha;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [CHAN_W-1:0]     out_red;
    logic [CHAN_W-1:0]     out_green;
    logic [CHAN_W-1:0]     out_blue;
    logic [CHAN_W-1:0]     out_alpha;
    logic [ROW_W-1:0]      out_row;
    logic [COL_W-1:0]      out_column;
    logic [NUM_COLOR-1:0]  clipped;
    logic                  run_last;

    int mismatches;
    int outstanding;
    int compared;
    int pixels_sent = 0;
    int frames_run = 0;
    int quiet_cycles = 0;
    bit calm = 1'b0;

    sharpen_3x3_conv_replicate_edge u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .alpha      (alpha),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_red    (out_red),
        .out_green  (out_green),
        .out_blue   (out_blue),
        .out_alpha  (out_alpha),
        .out_row    (out_row),
        .out_column (out_column),
        .clipped    (clipped),
        .run_last   (run_last)
    );

    sharpen_3x3_conv_replicate_edge_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .alpha       (alpha),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_red     (out_red),
        .out_green   (out_green),
        .out_blue    (out_blue),
        .out_alpha   (out_alpha),
        .out_row     (out_row),
        .out_column  (out_column),
        .clipped     (clipped),
        .run_last    (run_last),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .compared    (compared)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
        out_ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic reg_access(bit wr_en, reg_index_t idx, logic [DIM_W-1:0] value);
        logic [APB_DATA_W-1:0] noise;
        // Upper data bits carry junk; only the low bits belong to the register.
        noise = $urandom;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr_en;
        paddr   <= APB_ADDR_W'(4 * int'(idx));
        pwdata  <= {noise[APB_DATA_W-1:DIM_W], value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        // The bus goes idle before the next access.
        @(posedge clk);
    endtask

    task automatic set_size(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
        reg_access(1'b1, REG_FRAME_WIDTH, w);
        reg_access(1'b1, REG_FRAME_HEIGHT, h);
        reg_access(1'b0, REG_FRAME_WIDTH, '0);
        reg_access(1'b0, REG_FRAME_HEIGHT, '0);
    endtask

    function automatic pixel_t rand_pixel();
        pixel_t px;
        px = $urandom;
        // Saturated channels push the kernel sum to both clipping limits.
        if ($urandom_range(3) == 0) begin
            px.red   = $urandom_range(1) ? 8'hFF : 8'h00;
            px.green = $urandom_range(1) ? 8'hFF : 8'h00;
            px.blue  = $urandom_range(1) ? 8'hFF : 8'h00;
            px.alpha = $urandom_range(1) ? 8'hFF : 8'h00;
        end
        return px;
    endfunction

    task automatic send_pixel(pixel_t px);
        if (!calm)
            while ($urandom_range(99) < IDLE_PERCENT) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        in_valid <= 1'b1;
        {alpha, blue, green, red} <= px;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pixels_sent++;
    endtask

    task automatic send_pixels(int n, bit extremes);
        pixel_t px;
        for (int i = 0; i < n; i++) begin
            px = extremes ? ((i % 2 == 1) ? '1 : '0) : rand_pixel();
            send_pixel(px);
        end
    endtask

    // Hold off the sender until every predicted result has been seen.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial begin
        int               w;
        int               h;
        int               n;
        int               w2;
        int               h2;
        int               r;
        int               c;
        int               rest;
        int               first;
        logic [DIM_W-1:0] w_raw;
        logic [DIM_W-1:0] h_raw;

        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        in_valid = 1'b0;
        {alpha, blue, green, red} = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Start of a 640-wide frame, then shrink the width mid-row so the row
        // ends early; a height of 0 behaves as 2.
        send_pixels(3, 1'b1);
        settle();
        set_size(12'd3, 12'd0);
        send_pixels(4, 1'b1);
        settle();

        // Both sizes below range give a 2x2 frame.
        set_size(12'd0, 12'd1);
        send_pixels(4, 1'b1);
        settle();

        // Oversized width clamps to the line store; then cut the frame short by
        // shrinking the width mid-row and the height mid-frame.
        set_size(12'hFFF, 12'hFFF);
        send_pixels(3, 1'b0);
        settle();
        reg_access(1'b1, REG_FRAME_WIDTH, 12'd2);
        send_pixels(5, 1'b0);
        settle();
        reg_access(1'b1, REG_FRAME_HEIGHT, 12'd2);
        send_pixels(2, 1'b0);
        settle();

        first = pixels_sent;
        while (pixels_sent - first < RANDOM_PIXELS) begin
            frames_run++;
            calm = (frames_run >= 3 && frames_run <= 6);
            if ($urandom_range(5) == 0) begin
                w = $urandom_range(10, 40);
                h = $urandom_range(2, 3);
            end else begin
                w = $urandom_range(2, 9);
                h = ($urandom_range(5) == 0) ? $urandom_range(7, 12) : $urandom_range(2, 5);
            end
            w_raw = (w == 2 && $urandom_range(1) == 1) ? DIM_W'($urandom_range(1)) : DIM_W'(w);
            h_raw = (h == 2 && $urandom_range(1) == 1) ? DIM_W'($urandom_range(1)) : DIM_W'(h);
            set_size(w_raw, h_raw);

            if ($urandom_range(4) == 0) begin
                // Broken frame: stop part way, shrink the sizes, finish the frame.
                n = $urandom_range(1, w * h - 1);
                send_pixels(n, 1'b0);
                settle();
                w2 = $urandom_range(2, w);
                h2 = $urandom_range(2, h);
                r = n / w;
                c = n % w;
                rest = (c >= w2 - 1) ? 1 : w2 - c;
                if (r < h2 - 1)
                    rest += (h2 - 1 - r) * w2;
                set_size(DIM_W'(w2), DIM_W'(h2));
                send_pixels(rest, 1'b0);
            end else begin
                send_pixels(w * h, 1'b0);
            end
            settle();
        end
        calm = 1'b0;

        $display("Checked %0d output pixels from %0d input pixels in %0d random frames,",
                 compared, pixels_sent, frames_run);
        $display("covering edge replication, clipping, size clamping and mid-frame resizing.");
        if (mismatches == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
